// ===== rtl/pwc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwc_pkg: shared definitions for the parameter write command parser
// Character codes, the prefix text, the operation codes that pass from the
// front part to the back part, and the sizes of the internal queues.
// ----------------------------------------------------------------------------
`default_nettype none

package pwc_pkg;

  // Number of adjustable parameters; indexes at or above it fall back to 0.
  localparam int PARAM_COUNT = 8;
  localparam int TGT_W       = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

  // Line prefix that marks a command line.
  localparam int PREFIX_LEN   = 4;
  localparam int PREFIX_POS_W = $clog2(PREFIX_LEN + 1);
  localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);
  localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{8'h41, 8'h44, 8'h4A, 8'h3A};

  // Character codes used by the classifier.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Depth of the queues between the front, the back and the result port.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Classified payload character.
  typedef enum logic [2:0] {
    OP_COMMA,
    OP_SEMI,
    OP_BLANK,
    OP_PLUS,
    OP_MINUS,
    OP_DIGIT,
    OP_OTHER
  } op_kind_t;

  // One operation for the back part.
  typedef struct packed {
    op_kind_t   kind;
    logic [3:0] digit;
    logic       last;
  } op_t;

endpackage : pwc_pkg

`default_nettype wire

// ===== rtl/param_write_command_parser.sv =====
// ----------------------------------------------------------------------------
// param_write_command_parser: parameter write command line parser
// Parses "ADJ:" command lines of index,value pairs, one byte per
// transaction, and produces one parameter write per completed pair.
//
//   Channel   Handshake     Payload
//   input     push / full   line_byte[7:0], line_end
//   result    pop / empty   param_index[2:0], param_value[31:0] (signed)
//
// One byte is accepted per cycle while full is low. A byte passes the prefix check in the
// front and is written into the operation queue at the edge that accepts it;
// the back converts it once it heads that queue and the result queue has room,
// and the write that the byte ends is registered into the result queue. Reset
// clears the line state and empties both queues. A stalled result port fills
// the result queue, then the operation queue, and only then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module param_write_command_parser
  import pwc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    line_byte,
  input  wire logic          line_end,
  input  wire logic          push,
  output logic               full,
  output logic               empty,
  input  wire logic          pop,
  output logic [2:0]         param_index,
  output logic signed [31:0] param_value
);

  logic q_push;
  logic q_full;
  op_t  q_wr_data;
  op_t  q_rd_data;
  logic q_empty;
  logic q_take;

  // Front: prefix check and classification.
  pwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .line_byte (line_byte),
    .line_end  (line_end),
    .push      (push),
    .full      (full),
    .q_push    (q_push),
    .q_data    (q_wr_data),
    .q_full    (q_full)
  );

  // Operation queue between front and back.
  pwc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_take),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Back: token conversion and result queue.
  pwc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (!q_empty),
    .op_data     (q_rd_data),
    .op_take     (q_take),
    .pop         (pop),
    .empty       (empty),
    .param_index (param_index),
    .param_value (param_value)
  );

endmodule : param_write_command_parser

`default_nettype wire

// ===== rtl/pwc_front.sv =====
// ----------------------------------------------------------------------------
// pwc_front: prefix check and character classification
// Tracks the "ADJ:" prefix of each line, drops lines that fail it, and turns
// every payload character into an operation for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_front
  import pwc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] line_byte,
  input  wire logic       line_end,
  input  wire logic       push,
  output logic            full,
  output logic            q_push,
  output op_t             q_data,
  input  wire logic       q_full
);

  logic [PREFIX_POS_W-1:0] prefix_position;
  logic                    line_ignored;
  logic                    accept;
  logic                    prefix_done;
  logic                    prefix_match;

  // A transaction is taken whenever the operation queue has room.
  assign full         = q_full;
  assign accept       = push && !q_full;
  assign prefix_done  = (prefix_position == PREFIX_POS_W'(PREFIX_LEN));
  assign prefix_match =
    (line_byte == PREFIX_TEXT[prefix_position[PREFIX_IDX_W-1:0]]);

  // Classify the current byte.
  always_comb begin
    q_data.last  = line_end;
    q_data.digit = 4'(line_byte - CH_ZERO);
    if (line_byte == CH_COMMA) begin
      q_data.kind = OP_COMMA;
    end else if (line_byte == CH_SEMI) begin
      q_data.kind = OP_SEMI;
    end else if (line_byte == CH_SPACE || (line_byte >= CH_TAB && line_byte <= CH_CR)) begin
      q_data.kind = OP_BLANK;
    end else if (line_byte == CH_PLUS) begin
      q_data.kind = OP_PLUS;
    end else if (line_byte == CH_MINUS) begin
      q_data.kind = OP_MINUS;
    end else if (line_byte >= CH_ZERO && line_byte <= CH_NINE) begin
      q_data.kind = OP_DIGIT;
    end else begin
      q_data.kind = OP_OTHER;
    end
  end

  // Only payload bytes of an accepted line reach the back part.
  assign q_push = accept && !line_ignored && prefix_done;

  // Prefix tracking; every line end starts the next line fresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_position <= '0;
      line_ignored    <= 1'b0;
    end else if (accept) begin
      if (line_end) begin
        prefix_position <= '0;
        line_ignored    <= 1'b0;
      end else if (!line_ignored && !prefix_done) begin
        if (prefix_match) begin
          prefix_position <= prefix_position + 1'b1;
        end else begin
          line_ignored <= 1'b1;
        end
      end
    end
  end

endmodule : pwc_front

`default_nettype wire

// ===== rtl/pwc_queue.sv =====
// ----------------------------------------------------------------------------
// pwc_queue: short operation queue between the front and the back part
// A small first-in first-out buffer that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_queue
  import pwc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire op_t  wr_data,
  output logic      full,
  input  wire logic rd_en,
  output op_t       rd_data,
  output logic      empty
);

  op_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : pwc_queue

`default_nettype wire

// ===== rtl/pwc_back.sv =====
// ----------------------------------------------------------------------------
// pwc_back: token conversion and write generation
// Converts index and value tokens, keeps the target index, and places each
// parameter write into a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_back
  import pwc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   op_valid,
  input  wire op_t    op_data,
  output logic        op_take,
  input  wire logic   pop,
  output logic        empty,
  output logic [2:0]  param_index,
  output logic signed [31:0] param_value
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGNED,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  // Token state; the negated accumulator is kept alongside the plain one.
  phase_t            token_phase, token_phase_next;
  logic              token_negative, token_negative_next;
  logic [31:0]       token_accumulator, token_accumulator_next;
  logic [31:0]       token_neg_acc, token_neg_acc_next;
  logic [TGT_W-1:0]  target_index, target_index_next;

  logic [31:0]       value_cur;
  logic [31:0]       digit_ext;
  logic [31:0]       acc_step;
  logic [31:0]       neg_step;
  logic              index_ok;
  logic              emit_req;
  logic [31:0]       emit_value;

  // Result queue.
  logic [2:0]             res_index [QUEUE_DEPTH];
  logic [31:0]            res_value [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] res_wr_ptr;
  logic [QUEUE_PTR_W-1:0] res_rd_ptr;
  logic [QUEUE_CNT_W-1:0] res_count;
  logic                   res_wr;
  logic                   res_rd;

  // One operation is carried out per cycle while the result queue has room.
  assign op_take = op_valid && (res_count != QUEUE_CNT_W'(QUEUE_DEPTH));

  // Current token value and the next digit step of both accumulators.
  assign value_cur = token_negative ? token_neg_acc : token_accumulator;
  assign digit_ext = 32'(op_data.digit);
  assign acc_step  = {token_accumulator[28:0], 3'b000}
                   + {token_accumulator[30:0], 1'b0} + digit_ext;
  assign neg_step  = {token_neg_acc[28:0], 3'b000}
                   + {token_neg_acc[30:0], 1'b0} - digit_ext;
  assign index_ok  = !value_cur[31] && (value_cur < 32'(PARAM_COUNT));

  // Next state for one operation.
  always_comb begin
    token_phase_next       = token_phase;
    token_negative_next    = token_negative;
    token_accumulator_next = token_accumulator;
    token_neg_acc_next     = token_neg_acc;
    target_index_next      = target_index;
    emit_req               = 1'b0;
    emit_value             = value_cur;

    unique case (op_data.kind)
      OP_COMMA: begin
        target_index_next      = index_ok ? value_cur[TGT_W-1:0] : '0;
        token_phase_next       = PH_SKIP;
        token_negative_next    = 1'b0;
        token_accumulator_next = '0;
        token_neg_acc_next     = '0;
      end
      OP_SEMI: begin
        emit_req               = 1'b1;
        token_phase_next       = PH_SKIP;
        token_negative_next    = 1'b0;
        token_accumulator_next = '0;
        token_neg_acc_next     = '0;
      end
      default: begin
        unique case (token_phase)
          PH_SKIP: begin
            if (op_data.kind == OP_PLUS || op_data.kind == OP_MINUS) begin
              token_negative_next = (op_data.kind == OP_MINUS);
              token_phase_next    = PH_SIGNED;
            end else if (op_data.kind == OP_DIGIT) begin
              token_accumulator_next = digit_ext;
              token_neg_acc_next     = 32'd0 - digit_ext;
              token_phase_next       = PH_DIGITS;
            end else if (op_data.kind == OP_OTHER) begin
              token_phase_next = PH_STOPPED;
            end
          end
          PH_SIGNED, PH_DIGITS: begin
            if (op_data.kind == OP_DIGIT) begin
              token_accumulator_next = acc_step;
              token_neg_acc_next     = neg_step;
              token_phase_next       = PH_DIGITS;
            end else begin
              token_phase_next = PH_STOPPED;
            end
          end
          PH_STOPPED: begin
          end
        endcase
        emit_req   = op_data.last;
        emit_value = token_negative_next ? token_neg_acc_next : token_accumulator_next;
      end
    endcase

    // The line end returns the token and the index to their start values.
    if (op_data.last) begin
      token_phase_next       = PH_SKIP;
      token_negative_next    = 1'b0;
      token_accumulator_next = '0;
      token_neg_acc_next     = '0;
      target_index_next      = '0;
    end
  end

  // Token and index registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      token_phase       <= PH_SKIP;
      token_negative    <= 1'b0;
      token_accumulator <= '0;
      token_neg_acc     <= '0;
      target_index      <= '0;
    end else if (op_take) begin
      token_phase       <= token_phase_next;
      token_negative    <= token_negative_next;
      token_accumulator <= token_accumulator_next;
      token_neg_acc     <= token_neg_acc_next;
      target_index      <= target_index_next;
    end
  end

  // Result queue control.
  assign res_wr = op_take && emit_req;
  assign res_rd = pop && !empty;
  assign empty  = (res_count == '0);

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_index[res_wr_ptr] <= 3'(target_index);
      res_value[res_wr_ptr] <= emit_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (res_wr) begin
        res_wr_ptr <= (res_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_wr_ptr + 1'b1;
      end
      if (res_rd) begin
        res_rd_ptr <= (res_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_rd_ptr + 1'b1;
      end
      if (res_wr && !res_rd) begin
        res_count <= res_count + 1'b1;
      end else if (res_rd && !res_wr) begin
        res_count <= res_count - 1'b1;
      end
    end
  end

  // Oldest waiting result.
  assign param_index = res_index[res_rd_ptr];
  assign param_value = res_value[res_rd_ptr];

endmodule : pwc_back

`default_nettype wire
